// ===== rtl/sio_dcr_pkg.sv =====
// ----------------------------------------------------------------------------
// sio_dcr_pkg
// Shared types and codes of the serial-bus disk command responder.
// ----------------------------------------------------------------------------
`default_nettype none

package sio_dcr_pkg;

  // configuration register indexes
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 64;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_DRIVE_MODES     = 3'd0,
    REG_WRITE_PROTECT   = 3'd1,
    REG_IMAGE_PRESENT   = 3'd2,
    REG_SECTOR_LIM_LOW  = 3'd3,
    REG_SECTOR_LIM_HIGH = 3'd4,
    REG_EXTERNAL_LINKS  = 3'd5
  } cfg_reg_t;

  localparam int unsigned DEFAULT_NUM_DRIVES = 8;
  localparam int unsigned MAX_DRIVES         = 8;

  // bus codes
  localparam logic [7:0] DEV_DISK    = 8'h31;
  localparam logic [7:0] DEV_PRINTER = 8'h40;
  localparam logic [7:0] DIR_READ    = 8'h40;
  localparam logic [7:0] DIR_WRITE   = 8'h80;

  localparam logic [7:0] CMD_READ       = 8'h52; // R
  localparam logic [7:0] CMD_WRITE      = 8'h57; // W
  localparam logic [7:0] CMD_PUT        = 8'h50; // P
  localparam logic [7:0] CMD_STATUS     = 8'h53; // S
  localparam logic [7:0] CMD_GET_CONFIG = 8'h4E; // N
  localparam logic [7:0] CMD_SET_CONFIG = 8'h4F; // O
  localparam logic [7:0] CMD_FORMAT     = 8'h21; // !
  localparam logic [7:0] CMD_FORMAT_ED  = 8'h22; // "

  // drive modes
  localparam logic [3:0] MODE_OFF = 4'd0;
  localparam logic [3:0] MODE_EXT = 4'd1;
  localparam logic [3:0] MODE_35  = 4'd2;
  localparam logic [3:0] MODE_SD  = 4'd3;
  localparam logic [3:0] MODE_ED  = 4'd4;
  localparam logic [3:0] MODE_DD  = 4'd5;
  localparam logic [3:0] MODE_QD  = 4'd6;
  localparam logic [3:0] MODE_HD  = 4'd7;
  localparam logic [3:0] MODE_RAM = 4'd8;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_TIMEOUT = 2'd1,
    ST_NAK     = 2'd2,
    ST_DONE    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ROUTE_HERE     = 2'd0,
    ROUTE_EXTERNAL = 2'd1,
    ROUTE_PRINTER  = 2'd2
  } route_t;

  typedef enum logic [1:0] {
    XFER_NONE  = 2'd0,
    XFER_READ  = 2'd1,
    XFER_WRITE = 2'd2
  } xfer_kind_t;

  localparam int unsigned REPLY_MAX   = 12;
  localparam int unsigned REPLY_CNT_W = 4;
  localparam logic [REPLY_CNT_W-1:0] STATUS_LEN = 4'd4;
  localparam logic [REPLY_CNT_W-1:0] CONFIG_LEN = 4'd12;

  localparam int unsigned S_TDATA_W = 72;
  localparam int unsigned M_TDATA_W = 48;

  // one command block
  typedef struct packed {
    logic        host_io_ok;
    logic [15:0] sector;
    logic [15:0] byte_count;
    logic [7:0]  direction;
    logic [7:0]  cmd;
    logic [7:0]  unit_number;
    logic [7:0]  device_id;
  } cmd_block_t;

  // decoded answer of one command
  typedef struct packed {
    logic [REPLY_MAX-1:0][7:0] reply;
    logic [REPLY_CNT_W-1:0]    count;
    logic                      is_reply;
    logic [8:0]                xfer_bytes;
    logic [23:0]               xfer_offset;
    xfer_kind_t                kind;
    route_t                    route;
    status_t                   status;
  } answer_t;

endpackage

`default_nettype wire

// ===== rtl/sio_disk_command_responder_unit.sv =====
// ----------------------------------------------------------------------------
// sio_disk_command_responder_unit
// Answers serial-bus disk and printer command blocks for up to eight drives.
// ----------------------------------------------------------------------------
// Each command block taken on the slave stream is registered, decoded
// against the per-drive settings, and its answer is loaded into an output
// register. Most commands give one result transaction; a status command
// gives four and a get-configuration command twelve, one per cycle while
// m_tready is high, with tlast on the final one. One command is taken per
// cycle for single-result commands while m_tready is high; a status or
// configuration reply holds the next answer until the output register's
// reply shifter has sent its last byte. The input register takes a new
// command while the output register still holds an answer, so the two
// sides stall independently. Configuration writes are taken at any edge
// with cfg_we high and are meant to happen while no command is in flight;
// there is no read-back.
`default_nettype none

module sio_disk_command_responder_unit #(
  parameter int unsigned NUM_DRIVES = sio_dcr_pkg::DEFAULT_NUM_DRIVES
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // configuration write port
  input  wire logic                               cfg_we,
  input  wire logic [sio_dcr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [sio_dcr_pkg::CFG_DATA_W-1:0]  cfg_data,
  // command stream
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  // device_id[7:0], unit_number[15:8], cmd[23:16], direction[31:24],
  // byte_count[47:32], sector[63:48], host_io_ok[64], zero [71:65]
  input  wire logic [sio_dcr_pkg::S_TDATA_W-1:0]   s_tdata,
  // result stream
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  // status[1:0], route[3:2], transfer_kind[5:4], transfer_offset[29:6],
  // transfer_bytes[38:30], reply_byte[46:39], zero [47]
  output logic [sio_dcr_pkg::M_TDATA_W-1:0]        m_tdata,
  // reply_valid[0]
  output logic                                    m_tuser,
  output logic                                    m_tlast
);
  import sio_dcr_pkg::*;

  localparam int unsigned DRV_W = (NUM_DRIVES > 1) ? $clog2(NUM_DRIVES) : 1;

  // --------------------------------------------------------------------------
  // configuration registers, kept only for the drives that exist
  // --------------------------------------------------------------------------
  logic [3:0]            drive_mode [NUM_DRIVES];
  logic [15:0]           sector_limit [NUM_DRIVES];
  logic [NUM_DRIVES-1:0] write_protect;
  logic [NUM_DRIVES-1:0] image_present;
  logic                  ext_disk_link;
  logic                  ext_printer_link;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int d = 0; d < NUM_DRIVES; d++) begin
        drive_mode[d]   <= MODE_OFF;
        sector_limit[d] <= '0;
      end
      write_protect    <= '0;
      image_present    <= '0;
      ext_disk_link    <= 1'b0;
      ext_printer_link <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_DRIVE_MODES: begin
          for (int d = 0; d < NUM_DRIVES; d++) begin
            drive_mode[d] <= cfg_data[4*d +: 4];
          end
        end
        REG_WRITE_PROTECT:  write_protect <= cfg_data[NUM_DRIVES-1:0];
        REG_IMAGE_PRESENT:  image_present <= cfg_data[NUM_DRIVES-1:0];
        REG_SECTOR_LIM_LOW: begin
          for (int d = 0; d < NUM_DRIVES; d++) begin
            if (d < 4) sector_limit[d] <= cfg_data[16*(d%4) +: 16];
          end
        end
        REG_SECTOR_LIM_HIGH: begin
          for (int d = 0; d < NUM_DRIVES; d++) begin
            if (d >= 4) sector_limit[d] <= cfg_data[16*(d%4) +: 16];
          end
        end
        REG_EXTERNAL_LINKS: begin
          ext_disk_link    <= cfg_data[0];
          ext_printer_link <= cfg_data[1];
        end
        default: ; // unused indexes are ignored
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // input register
  // --------------------------------------------------------------------------
  logic       in_valid;
  cmd_block_t in_cmd;
  logic       load;      // answer register takes the decoded command
  logic       out_valid;
  answer_t    out_ans;
  logic       out_done;  // final result transaction of the held answer

  assign s_tready = !in_valid || load;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      in_cmd <= cmd_block_t'(s_tdata[$bits(cmd_block_t)-1:0]);
    end
  end

  // --------------------------------------------------------------------------
  // decode
  // --------------------------------------------------------------------------
  answer_t          ans;
  logic [7:0]       unit_m1;
  logic             unit_ok;
  logic [DRV_W-1:0] drv;
  logic [3:0]       md;
  logic [15:0]      limit;
  logic [15:0]      limit_m1;
  logic [15:0]      sec_m1;
  logic             wp;
  logic             img;
  logic             is_ed;
  logic             is_hd;
  logic             sd_ed;
  logic             dd;
  logic             small_sec;
  logic             size_bad;
  logic             rd;
  logic             wr;
  logic [8:0]       nbytes;
  logic [23:0]      offset;

  always_comb begin
    unit_m1  = in_cmd.unit_number - 8'd1;
    unit_ok  = (in_cmd.unit_number != 8'd0) && ({1'b0, unit_m1} < 9'(NUM_DRIVES));
    drv      = unit_m1[DRV_W-1:0];
    md       = drive_mode[drv];
    limit    = sector_limit[drv];
    limit_m1 = limit - 16'd1;
    wp       = write_protect[drv];
    img      = image_present[drv];
    is_ed    = (md == MODE_ED);
    is_hd    = (md == MODE_HD);
    sd_ed    = (md == MODE_SD) || is_ed;
    dd       = (md == MODE_QD) || (md == MODE_DD) || is_hd || (md == MODE_RAM);

    // sector request checks
    sec_m1    = in_cmd.sector - 16'd1;
    small_sec = (in_cmd.sector < 16'd4) || sd_ed;
    if (small_sec) begin
      size_bad = (in_cmd.byte_count != 16'd128);
    end else if (is_hd) begin
      size_bad = 1'b0;
    end else begin
      size_bad = (in_cmd.byte_count != 16'd256);
    end
    nbytes = (!small_sec && is_hd) ? 9'd256 : in_cmd.byte_count[8:0];
    offset = sd_ed ? {1'b0, sec_m1, 7'b0} : {sec_m1, 8'b0};
    rd     = (in_cmd.cmd == CMD_READ) && (in_cmd.direction == DIR_READ);
    wr     = (in_cmd.cmd == CMD_WRITE) || (in_cmd.cmd == CMD_PUT);

    ans = '0;
    if (in_cmd.device_id == DEV_PRINTER) begin
      if (ext_printer_link) begin
        ans.route = ROUTE_EXTERNAL;
      end else if (in_cmd.cmd == CMD_STATUS || in_cmd.cmd == CMD_WRITE) begin
        ans.route = ROUTE_PRINTER;
      end
    end else if (in_cmd.device_id != DEV_DISK || (unit_ok && md == MODE_EXT)) begin
      // someone else on the bus may answer
      ans.status = ext_disk_link ? ST_OK : ST_TIMEOUT;
      ans.route  = ext_disk_link ? ROUTE_EXTERNAL : ROUTE_HERE;
    end else if (!unit_ok || md == MODE_OFF) begin
      ans.status = ST_TIMEOUT;
    end else if (md == MODE_35 || !img) begin
      ans.status = ST_NAK;
    end else begin
      case (in_cmd.cmd)
        CMD_FORMAT_ED:  ans.status = is_ed ? ST_OK : ST_NAK;
        CMD_FORMAT:     ans.status = wp ? ST_DONE : ST_OK;
        CMD_SET_CONFIG: ans.status = ST_OK;
        CMD_STATUS: begin
          ans.is_reply = 1'b1;
          ans.count    = STATUS_LEN;
          ans.reply[0] = {is_ed, 1'b0, dd, 1'b0, wp, 3'b000};
          ans.reply[1] = 8'hFF;
          ans.reply[2] = 8'hE0;
          ans.reply[3] = 8'h00;
        end
        CMD_GET_CONFIG: begin
          ans.is_reply = 1'b1;
          ans.count    = CONFIG_LEN;
          if (is_hd) begin
            // sector count field carries limit minus one
            ans.reply[0] = 8'h01;
            ans.reply[1] = 8'h00;
            ans.reply[2] = limit_m1[7:0];
            ans.reply[3] = limit_m1[15:8];
          end else begin
            ans.reply[0] = 8'h28;
            ans.reply[1] = 8'h02;
            ans.reply[2] = 8'h00;
            ans.reply[3] = is_ed ? 8'h1A : 8'h12;
          end
          ans.reply[4] = 8'h00;
          ans.reply[5] = dd ? 8'h04 : 8'h00;
          ans.reply[6] = dd ? 8'h01 : 8'h00;
          ans.reply[7] = dd ? 8'h00 : 8'h80;
          for (int k = 8; k < REPLY_MAX; k++) begin
            ans.reply[k] = 8'hFF;
          end
        end
        CMD_READ, CMD_WRITE, CMD_PUT: begin
          if (in_cmd.sector == 16'd0 || size_bad || in_cmd.sector > limit) begin
            ans.status = ST_NAK;
          end else if (md == MODE_RAM) begin
            // ram disk ignores protection, direction of writes and host status
            if (rd || wr) begin
              ans.kind        = rd ? XFER_READ : XFER_WRITE;
              ans.xfer_offset = offset;
              ans.xfer_bytes  = nbytes;
            end
          end else if (rd) begin
            ans.status      = in_cmd.host_io_ok ? ST_OK : ST_DONE;
            ans.kind        = XFER_READ;
            ans.xfer_offset = offset;
            ans.xfer_bytes  = nbytes;
          end else if (wr) begin
            if (in_cmd.direction != DIR_WRITE) begin
              ans.status = ST_NAK;
            end else if (wp) begin
              ans.status = ST_DONE;
            end else begin
              ans.status      = in_cmd.host_io_ok ? ST_OK : ST_DONE;
              ans.kind        = XFER_WRITE;
              ans.xfer_offset = offset;
              ans.xfer_bytes  = nbytes;
            end
          end
        end
        default: ans.status = ST_NAK;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // answer register and reply shifter
  // --------------------------------------------------------------------------
  assign out_done = !out_ans.is_reply || (out_ans.count == REPLY_CNT_W'(1));
  assign load     = !out_valid || (m_tready && out_done);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= in_valid;
    end
    if (load) begin
      if (in_valid) out_ans <= ans;
    end else if (m_tready) begin
      // one reply byte goes out, the next moves to the front
      out_ans.reply <= {8'h00, out_ans.reply[REPLY_MAX-1:1]};
      out_ans.count <= out_ans.count - REPLY_CNT_W'(1);
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_ans.is_reply;
  assign m_tlast  = out_done;
  assign m_tdata  = {1'b0, out_ans.reply[0], out_ans.xfer_bytes, out_ans.xfer_offset,
                     out_ans.kind, out_ans.route, out_ans.status};

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_reply_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ans.is_reply |-> out_ans.count != '0)
    else $error("reply held with no bytes left");

  a_stall_has_item: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> in_valid && out_valid)
    else $error("input stalled with nothing held");

  a_no_xfer_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ans.kind == XFER_NONE |->
      out_ans.xfer_offset == '0 && out_ans.xfer_bytes == '0)
    else $error("transfer fields set without a transfer");

  a_reply_plain: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ans.is_reply |->
      out_ans.status == ST_OK && out_ans.route == ROUTE_HERE && out_ans.kind == XFER_NONE)
    else $error("reply byte carries status or transfer");

  a_handoff: assert property (@(posedge clk) disable iff (rst)
    in_valid && load |=> out_valid)
    else $error("decoded command lost at handoff");

endmodule

`default_nettype wire
